>>> rtl/bsc_pkg.sv
package bsc_pkg;

	localparam int PROCESSES_DEF = 8;
	localparam int RESOURCES_DEF = 4;

	localparam int VAL_W  = 8;
	localparam int WORK_W = 12;
	localparam int PID_W  = 3;
	localparam int PIX_W  = 3;
	localparam int RIX_W  = 2;
	localparam int ACT_W  = 2;

	localparam logic [WORK_W-1:0] WORK_MAX = {WORK_W{1'b1}};

	localparam logic [ACT_W-1:0] ACT_LOAD_ROW   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LOAD_AVAIL = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CHECK      = 2'd2;

	typedef struct packed {
		logic             start;
		logic             advance;
		logic             active;
		logic             wr_en;
		logic [RIX_W-1:0] wr_res;
		logic [VAL_W-1:0] wr_claim;
		logic [VAL_W-1:0] wr_held;
	} cell_ctl_t;

endpackage

>>> rtl/bsc_cell.sv
module bsc_cell #(
	parameter int RESOURCES = bsc_pkg::RESOURCES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bsc_pkg::cell_ctl_t        ctl,
	input  logic [bsc_pkg::WORK_W-1:0] work_in [RESOURCES],
	output logic [bsc_pkg::WORK_W-1:0] work_q  [RESOURCES],
	output logic                      fire
);
	import bsc_pkg::*;

	logic [VAL_W-1:0]  claim_q [RESOURCES];
	logic [VAL_W-1:0]  held_q  [RESOURCES];
	logic              finished_q;
	logic [WORK_W:0]   total   [RESOURCES];
	logic [WORK_W-1:0] sum_sat [RESOURCES];
	logic [RESOURCES-1:0] fit_vec;

	// A process fits when claim minus held is no more than work, that is
	// when claim is no more than work plus held.
	always_comb begin
		for (int r = 0; r < RESOURCES; r++) begin
			total[r]   = {1'b0, work_in[r]} + (WORK_W+1)'(held_q[r]);
			fit_vec[r] = total[r] >= (WORK_W+1)'(claim_q[r]);
			sum_sat[r] = total[r][WORK_W] ? WORK_MAX : total[r][WORK_W-1:0];
		end
		fire = ctl.active && !finished_q && (&fit_vec);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finished_q <= 1'b0;
			for (int r = 0; r < RESOURCES; r++) begin
				claim_q[r] <= '0;
				held_q[r]  <= '0;
			end
		end else begin
			for (int r = 0; r < RESOURCES; r++) begin
				if (ctl.wr_en && (int'(ctl.wr_res) == r)) begin
					claim_q[r] <= ctl.wr_claim;
					held_q[r]  <= ctl.wr_held;
				end
			end
			if (ctl.start) begin
				finished_q <= 1'b0;
			end else if (fire && ctl.advance) begin
				finished_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			for (int r = 0; r < RESOURCES; r++) begin
				work_q[r] <= fire ? sum_sat[r] : work_in[r];
			end
		end
	end

endmodule

>>> rtl/bankers_safety_check_unit.sv
// Loads are accepted back to back while no check runs.
// A check moves the work vector along the row of process cells, one cell per
// cycle while the result side does not stall; each sequence entry is
// registered and leaves in the cycle after the cell that finds it. Reset
// clears the claim, held and available tables to zero and leaves the block
// idle with no result pending.
module bankers_safety_check_unit #(
	parameter int PROCESSES = bsc_pkg::PROCESSES_DEF,
	parameter int RESOURCES = bsc_pkg::RESOURCES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic [bsc_pkg::ACT_W-1:0] action,
	input  logic [bsc_pkg::PIX_W-1:0] process_index,
	input  logic [bsc_pkg::RIX_W-1:0] resource_index,
	input  logic [bsc_pkg::VAL_W-1:0] claim_value,
	input  logic [bsc_pkg::VAL_W-1:0] held_value,
	input  logic [bsc_pkg::VAL_W-1:0] available_value,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output logic [bsc_pkg::PID_W-1:0] process_id,
	output logic                      entry_valid,
	output logic                      is_safe,
	output logic                      last
);
	import bsc_pkg::*;

	localparam int PW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
	localparam int CW = $clog2(PROCESSES + 1);

	logic              busy_q;
	logic              first_q;
	logic              found_q;
	logic [PW-1:0]     pos_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_n;
	logic [VAL_W-1:0]  avail_q [RESOURCES];

	logic              out_valid_q;
	logic [PID_W-1:0]  out_pid_q;
	logic              out_entry_q;
	logic              out_safe_q;
	logic              out_last_q;

	logic              req_fire;
	logic              start;
	logic              advance;
	logic              step;
	logic              at_end;
	logic              fire_any;
	logic [PROCESSES-1:0] fire_vec;

	cell_ctl_t         ctl [PROCESSES];
	logic [WORK_W-1:0] work_chain [PROCESSES][RESOURCES];
	logic [WORK_W-1:0] seed_work  [RESOURCES];

	assign req_ready = !busy_q;
	assign req_fire  = req_valid && req_ready;
	assign start     = req_fire && (action == ACT_CHECK);
	assign advance   = !out_valid_q || rsp_ready;
	assign step      = busy_q && advance;
	assign at_end    = pos_q == PW'(PROCESSES - 1);
	assign fire_any  = |fire_vec;
	assign count_n   = count_q + CW'(1);

	always_comb begin
		for (int i = 0; i < PROCESSES; i++) begin
			ctl[i].start    = start;
			ctl[i].advance  = step;
			ctl[i].active   = busy_q && (pos_q == PW'(i));
			ctl[i].wr_en    = req_fire && (action == ACT_LOAD_ROW)
			                  && (int'(process_index) == i)
			                  && (int'(resource_index) < RESOURCES);
			ctl[i].wr_res   = resource_index;
			ctl[i].wr_claim = claim_value;
			ctl[i].wr_held  = held_value;
		end
		for (int r = 0; r < RESOURCES; r++) begin
			seed_work[r] = first_q ? WORK_W'(avail_q[r]) : work_chain[PROCESSES-1][r];
		end
	end

	for (genvar i = 0; i < PROCESSES; i++) begin : g_cell
		if (i == 0) begin : g_head
			bsc_cell #(.RESOURCES(RESOURCES)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl[i]),
				.work_in (seed_work),
				.work_q  (work_chain[i]),
				.fire    (fire_vec[i])
			);
		end else begin : g_body
			bsc_cell #(.RESOURCES(RESOURCES)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl[i]),
				.work_in (work_chain[i-1]),
				.work_q  (work_chain[i]),
				.fire    (fire_vec[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			first_q     <= 1'b0;
			found_q     <= 1'b0;
			pos_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			for (int r = 0; r < RESOURCES; r++) begin
				avail_q[r] <= '0;
			end
		end else begin
			if (req_fire && (action == ACT_LOAD_AVAIL)) begin
				for (int r = 0; r < RESOURCES; r++) begin
					if (int'(resource_index) == r) begin
						avail_q[r] <= available_value;
					end
				end
			end
			if (step && (fire_any || (at_end && !found_q))) begin
				out_valid_q <= 1'b1;
			end else if (advance) begin
				out_valid_q <= 1'b0;
			end
			if (start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
				found_q <= 1'b0;
				pos_q   <= '0;
				count_q <= '0;
			end else if (step) begin
				first_q <= 1'b0;
				pos_q   <= at_end ? '0 : pos_q + PW'(1);
				found_q <= at_end ? 1'b0 : (found_q || fire_any);
				if (fire_any) begin
					count_q <= count_n;
					if (count_n == CW'(PROCESSES)) begin
						busy_q <= 1'b0;
					end
				end else if (at_end && !found_q) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (fire_any) begin
				out_pid_q   <= PID_W'(pos_q);
				out_entry_q <= 1'b1;
				out_safe_q  <= count_n == CW'(PROCESSES);
				out_last_q  <= count_n == CW'(PROCESSES);
			end else begin
				out_pid_q   <= '0;
				out_entry_q <= 1'b0;
				out_safe_q  <= 1'b0;
				out_last_q  <= 1'b1;
			end
		end
	end

	assign rsp_valid   = out_valid_q;
	assign process_id  = out_pid_q;
	assign entry_valid = out_entry_q;
	assign is_safe     = out_safe_q;
	assign last        = out_last_q;

	a_one_cell_fires: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(fire_vec))
		else $error("More than one cell finished a process in one cycle.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(PROCESSES))
		else $error("Finished count exceeds the number of processes.");

	a_end_has_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> (out_valid_q && out_last_q))
		else $error("Check ended without a final beat.");

	a_safe_is_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_safe_q) |-> (out_entry_q && out_last_q))
		else $error("Safe verdict on a beat that is not a final entry.");

endmodule
